// ===== hw/rtl/snsel_pkg.sv =====
// Shared types, codes and constants of the server node selector.
package snsel_pkg;

    // Fixed field widths
    localparam int NODE_ID_W = 8;
    localparam int DATA_W    = 32;
    localparam int OPCODE_W  = 3;
    localparam int STATUS_W  = 2;
    localparam int MODE_W    = 2;

    // Defaults for top-level parameters
    localparam int MAX_NODES_DEF = 16;
    localparam int ID_BITS_DEF   = 8;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_HEALTH = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_STATS  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SELECT = 3'd4;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // Selection modes
    typedef enum logic [MODE_W-1:0] {
        MODE_RR       = 2'd0,
        MODE_LEAST_CN = 2'd1,
        MODE_WRR      = 2'd2,
        MODE_LEAST_RT = 2'd3
    } t_mode;

    // A metric at or above its ceiling never wins a least scan
    localparam logic [DATA_W-1:0] CONN_CEILING = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] TIME_CEILING = 32'd1_000_000_000;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [NODE_ID_W-1:0] id;
        logic                 healthy;
        logic [DATA_W-1:0]    conn;
        logic [DATA_W-1:0]    rtime;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Result of the shared subtract/compare unit
    typedef struct packed {
        logic              lt;
        logic [DATA_W-1:0] diff;
    } t_alu_res;

endpackage

// ===== hw/rtl/snsel_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module snsel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/snsel_alu.sv =====
// Shared 32-bit subtract and unsigned less-than unit.
module snsel_alu
    import snsel_pkg::*;
(
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output t_alu_res          o_res
);

    logic [DATA_W:0] diff_ext;

    // Borrow out of a - b marks a < b
    assign diff_ext   = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.lt   = diff_ext[DATA_W];
    assign o_res.diff = diff_ext[DATA_W-1:0];

endmodule

// ===== hw/rtl/server_node_selector_core.sv =====
// Server node selector top level. Add: result in the cycle after the input transfer.
// Remove, set health, set stats and least selection: a scan of up to N entries
// (one RAM read per cycle). Round robin and weighted round robin selection: 32 restoring
// divide steps on the shared unit, then one fetch. One item at a time; ready returns
// the cycle after the result transfer. Reset (synchronous, active low) empties the table,
// clears both turn counters and sets round robin mode; table RAM contents are not cleared.
module server_node_selector_core
    import snsel_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int ID_BITS   = ID_BITS_DEF,
    localparam int SLOT_W   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
    localparam int CNT_W    = $clog2(MAX_NODES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [OPCODE_W-1:0]  i_opcode,
    input  logic [NODE_ID_W-1:0] i_node_id,
    input  logic                 i_healthy,
    input  logic [DATA_W-1:0]    i_connections,
    input  logic [DATA_W-1:0]    i_response_time,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [NODE_ID_W-1:0] o_chosen_id,
    output logic [SLOT_W-1:0]    o_chosen_slot,
    output logic [CNT_W-1:0]     o_node_count,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [MODE_W-1:0]    i_cfg_select_mode
);

    localparam logic [NODE_ID_W-1:0] ID_MASK = (ID_BITS >= NODE_ID_W) ? {NODE_ID_W{1'b1}}
                                               : NODE_ID_W'((1 << ID_BITS) - 1);
    localparam int STEP_W = $clog2(DATA_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(MAX_NODES);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DIV   = 5'b00100,
        S_FETCH = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    t_mode                 r_mode;
    logic [CNT_W-1:0]      r_total, n_total;
    logic [DATA_W-1:0]     r_plain, n_plain;
    logic [DATA_W-1:0]     r_weighted, n_weighted;

    logic [OPCODE_W-1:0]   r_op, n_op;
    logic [NODE_ID_W-1:0]  r_id, n_id;
    logic                  r_healthy, n_healthy;
    logic [DATA_W-1:0]     r_conn, n_conn;
    logic [DATA_W-1:0]     r_rt, n_rt;
    logic [SLOT_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]      r_wr, n_wr;
    logic [DATA_W-1:0]     r_best, n_best;
    logic [SLOT_W-1:0]     r_best_slot, n_best_slot;
    logic [NODE_ID_W-1:0]  r_best_id, n_best_id;
    logic [DATA_W-1:0]     r_quo, n_quo;
    logic [CNT_W-1:0]      r_rem, n_rem;
    logic [STEP_W-1:0]     r_step, n_step;
    t_status               r_status, n_status;
    logic [NODE_ID_W-1:0]  r_cid, n_cid;
    logic [SLOT_W-1:0]     r_cslot, n_cslot;

    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    t_entry                ram_wdata;
    logic [SLOT_W-1:0]     ram_raddr;
    t_entry                ram_rdata;
    logic [DATA_W-1:0]     alu_a, alu_b;
    t_alu_res              alu_res;

    logic [CNT_W:0]        rem_sh;
    logic [CNT_W-1:0]      rem_nx;
    logic                  is_last;
    logic [DATA_W-1:0]     metric;

    snsel_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NODES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    snsel_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // Divide step and scan helpers
    assign rem_sh  = {r_rem, r_quo[DATA_W-1]};
    assign rem_nx  = alu_res.lt ? rem_sh[CNT_W-1:0] : alu_res.diff[CNT_W-1:0];
    assign is_last = (CNT_W'(r_idx) + CNT_W'(1)) == r_total;
    assign metric  = (r_mode == MODE_LEAST_RT) ? ram_rdata.rtime : ram_rdata.conn;

    // Route the shared unit: divide compare or metric compare
    always_comb begin
        if (r_state == S_DIV) begin
            alu_a = DATA_W'(rem_sh);
            alu_b = DATA_W'(r_total);
        end else begin
            alu_a = metric;
            alu_b = r_best;
        end
    end

    // Sequencer
    always_comb begin
        logic [CNT_W-1:0]     wr_nx;
        logic [NODE_ID_W-1:0] bid_nx;
        logic [SLOT_W-1:0]    bslot_nx;

        n_state     = r_state;
        n_total     = r_total;
        n_plain     = r_plain;
        n_weighted  = r_weighted;
        n_op        = r_op;
        n_id        = r_id;
        n_healthy   = r_healthy;
        n_conn      = r_conn;
        n_rt        = r_rt;
        n_idx       = r_idx;
        n_wr        = r_wr;
        n_best      = r_best;
        n_best_slot = r_best_slot;
        n_best_id   = r_best_id;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_step      = r_step;
        n_status    = r_status;
        n_cid       = r_cid;
        n_cslot     = r_cslot;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = ram_rdata;
        ram_raddr   = '0;
        wr_nx       = r_wr;
        bid_nx      = r_best_id;
        bslot_nx    = r_best_slot;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op      = i_opcode;
                    n_id      = i_node_id & ID_MASK;
                    n_healthy = i_healthy;
                    n_conn    = i_connections;
                    n_rt      = i_response_time;
                    n_status  = ST_DONE;
                    n_cid     = '0;
                    n_cslot   = '0;
                    n_idx     = '0;
                    n_wr      = '0;
                    n_state   = S_OUT;
                    case (i_opcode)
                        OP_ADD: begin
                            // Append at the end unless full
                            if (r_total >= FULL_CNT) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we            = 1'b1;
                                ram_waddr         = r_total[SLOT_W-1:0];
                                ram_wdata.id      = i_node_id & ID_MASK;
                                ram_wdata.healthy = i_healthy;
                                ram_wdata.conn    = i_connections;
                                ram_wdata.rtime   = i_response_time;
                                n_total           = r_total + CNT_W'(1);
                            end
                        end
                        OP_REMOVE, OP_HEALTH, OP_STATS: begin
                            if (r_total == '0) begin
                                n_status = ST_MISSING;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_SELECT: begin
                            if (r_total == '0) begin
                                n_status = ST_EMPTY;
                            end else if (r_mode == MODE_RR || r_mode == MODE_WRR) begin
                                n_quo   = (r_mode == MODE_RR) ? r_plain : r_weighted;
                                n_rem   = '0;
                                n_step  = '0;
                                n_state = S_DIV;
                            end else begin
                                n_best      = (r_mode == MODE_LEAST_RT) ? TIME_CEILING
                                                                        : CONN_CEILING;
                                n_best_slot = '0;
                                n_best_id   = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        default: begin
                            // Unknown opcode: report done, change nothing
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Entry r_idx is on the read data; prefetch the next one
                ram_raddr = r_idx + SLOT_W'(1);
                n_idx     = r_idx + SLOT_W'(1);
                case (r_op)
                    OP_REMOVE: begin
                        // Compact the kept entries toward the front
                        if (ram_rdata.id != r_id) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_wr[SLOT_W-1:0];
                            wr_nx     = r_wr + CNT_W'(1);
                        end
                        n_wr = wr_nx;
                        if (is_last) begin
                            n_total  = wr_nx;
                            n_status = (wr_nx == r_total) ? ST_MISSING : ST_DONE;
                            n_state  = S_OUT;
                        end
                    end
                    OP_HEALTH, OP_STATS: begin
                        // Update the first match in place
                        if (ram_rdata.id == r_id) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_idx;
                            if (r_op == OP_HEALTH) begin
                                ram_wdata.healthy = r_healthy;
                            end else begin
                                ram_wdata.conn  = r_conn;
                                ram_wdata.rtime = r_rt;
                            end
                            n_state = S_OUT;
                        end else if (is_last) begin
                            n_status = ST_MISSING;
                            n_state  = S_OUT;
                        end
                    end
                    default: begin
                        // Least scan; slot 0 is the fallback choice
                        if (r_idx == '0) begin
                            bid_nx = ram_rdata.id;
                        end
                        if (ram_rdata.healthy && alu_res.lt) begin
                            n_best   = metric;
                            bslot_nx = r_idx;
                            bid_nx   = ram_rdata.id;
                        end
                        n_best_id   = bid_nx;
                        n_best_slot = bslot_nx;
                        if (is_last) begin
                            n_cid   = bid_nx;
                            n_cslot = bslot_nx;
                            n_state = S_OUT;
                        end
                    end
                endcase
            end

            S_DIV: begin
                // One restoring divide step per cycle: counter mod node count
                n_quo  = {r_quo[DATA_W-2:0], 1'b0};
                n_rem  = rem_nx;
                n_step = r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    ram_raddr = rem_nx[SLOT_W-1:0];
                    n_cslot   = rem_nx[SLOT_W-1:0];
                    if (r_mode == MODE_RR) begin
                        n_plain = r_plain + DATA_W'(1);
                    end else begin
                        n_weighted = r_weighted + DATA_W'(1);
                    end
                    n_state = S_FETCH;
                end
            end

            S_FETCH: begin
                n_cid   = ram_rdata.id;
                n_state = S_OUT;
            end

            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= MODE_RR;
            r_total    <= '0;
            r_plain    <= '0;
            r_weighted <= '0;
        end else begin
            r_state    <= n_state;
            r_total    <= n_total;
            r_plain    <= n_plain;
            r_weighted <= n_weighted;
            if (i_cfg_valid) begin
                r_mode <= t_mode'(i_cfg_select_mode);
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_id        <= n_id;
        r_healthy   <= n_healthy;
        r_conn      <= n_conn;
        r_rt        <= n_rt;
        r_idx       <= n_idx;
        r_wr        <= n_wr;
        r_best      <= n_best;
        r_best_slot <= n_best_slot;
        r_best_id   <= n_best_id;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_step      <= n_step;
        r_status    <= n_status;
        r_cid       <= n_cid;
        r_cslot     <= n_cslot;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_status      = r_status;
    assign o_chosen_id   = r_cid;
    assign o_chosen_slot = r_cslot;
    assign o_node_count  = r_total;
    assign o_cfg_ready   = 1'b1;

endmodule

// ===== hw/rtl/snsel_checker.sv =====
// Port-level assertions for the server node selector, bound to the top level.
module snsel_checker
    import snsel_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    localparam int SLOT_W   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
    localparam int CNT_W    = $clog2(MAX_NODES + 1)
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [STATUS_W-1:0]  o_status,
    input logic [NODE_ID_W-1:0] o_chosen_id,
    input logic [SLOT_W-1:0]    o_chosen_slot,
    input logic [CNT_W-1:0]     o_node_count
);

    // A held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_chosen_id)
            && $stable(o_chosen_slot) && $stable(o_node_count))
        else $error("result changed while stalled");

    // Never ready for input while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("ready while result pending");

    // An accepted item makes the block busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after input transfer");

    // Table count never exceeds capacity while a result is shown
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_node_count <= CNT_W'(MAX_NODES))
        else $error("node count beyond capacity");

    // An empty select reports an empty table and no choice
    a_empty_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |->
            o_node_count == '0 && o_chosen_id == '0 && o_chosen_slot == '0)
        else $error("empty status with nonempty table or a choice");

endmodule

bind server_node_selector_core snsel_checker #(
    .MAX_NODES (MAX_NODES)
) u_snsel_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_chosen_id   (o_chosen_id),
    .o_chosen_slot (o_chosen_slot),
    .o_node_count  (o_node_count)
);
